// ----- rtl/bra_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bra_pkg
// Shared types, codes and defaults of the bitmap run allocator.
// ----------------------------------------------------------------------------
package bra_pkg;

  localparam int MAX_ENTRIES_DEF = 1024;
  localparam int WORD_BITS_DEF   = 8;
  localparam int MAX_RUN_DEF     = 16;

  localparam int KIND_W   = 2;
  localparam int INDEX_W  = 10;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;
  localparam int ENTRY_W  = 10;
  localparam int REG_W    = 11;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [REG_W-1:0] ENTRIES_RESET = 11'd1024;

  localparam logic REG_ENTRIES_IN_USE = 1'b0;

  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SET   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;
  localparam logic [KIND_W-1:0] KIND_TEST  = 2'd3;

  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NO_SPACE = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RANGE    = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_RMW,
    ST_EMIT
  } bra_state_t;

endpackage : bra_pkg
`default_nettype wire

// ----- rtl/bra_bitmap_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bra_bitmap_ram
// Occupancy word store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bra_bitmap_ram #(
  parameter int DEPTH  = 128,
  parameter int WIDTH  = 8,
  parameter int ADDR_W = 7
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : bra_bitmap_ram
`default_nettype wire

// ----- rtl/bra_pick_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bra_pick_unit
// Lowest free entry of one occupancy word, bounded by the entry limit.
// ----------------------------------------------------------------------------
module bra_pick_unit #(
  parameter int WORD_BITS = 8,
  parameter int BASE_W    = 11,
  parameter int LIMIT_W   = 11,
  parameter int POS_W     = 3
) (
  input  wire logic [WORD_BITS-1:0] word_i,
  input  wire logic [BASE_W-1:0]    base_i,
  input  wire logic [LIMIT_W-1:0]   limit_i,
  output logic                      any_o,
  output logic      [POS_W-1:0]     pos_o
);

  logic [31:0]          span;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] avail;

  always_comb begin
    span = '0;
    if (32'(limit_i) > 32'(base_i)) begin
      span = 32'(limit_i) - 32'(base_i);
    end
    for (int b = 0; b < WORD_BITS; b++) begin
      mask[b] = (32'(b) < span);
    end
    avail = ~word_i & mask;
    any_o = |avail;
    pos_o = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (avail[b]) begin
        pos_o = POS_W'(b);
      end
    end
  end

endmodule : bra_pick_unit
`default_nettype wire

// ----- rtl/bitmap_run_allocator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_run_allocator
// First-fit run allocator over an occupancy bitmap with set, clear and test.
//
//   channel  dir  ports                         contents
//   in       in   in_tvalid/tready/tdata/tuser  request: kind, index, count
//   out      out  out_tvalid/tready/tdata/...   result: status, entry, bit, last
//   cfg      in   cfg_psel/penable/pwrite/...   entries_in_use at byte 0
//
// After reset a clearing pass writes zero to all NUM_WORDS words of the bitmap;
// no item is accepted meanwhile.
// Set, clear and test read the word (set and clear write it back updated),
// then emit; out-of-range indices and bad allocate counts emit directly.
// Allocate walks the words twice through one pick unit: a probe walk finds
// free entries up to the requested count, a commit walk marks and emits them;
// a failing allocate ends after one walk over all words in range and emits no-space.
// One item is in work at a time; a full output register stalls emission.
// WORD_BITS must be a power of two.
// ----------------------------------------------------------------------------
module bitmap_run_allocator #(
  parameter int MAX_ENTRIES = bra_pkg::MAX_ENTRIES_DEF,
  parameter int WORD_BITS   = bra_pkg::WORD_BITS_DEF,
  parameter int MAX_RUN     = bra_pkg::MAX_RUN_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [bra_pkg::IN_TDATA_W-1:0]    in_tdata,   // index, count
  input  wire logic [bra_pkg::KIND_W-1:0]        in_tuser,   // kind
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic      [bra_pkg::OUT_TDATA_W-1:0]   out_tdata,  // entry, bit_value
  output logic      [bra_pkg::STATUS_W-1:0]      out_tuser,  // status
  output logic                                   out_tlast,
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [bra_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  wire logic [bra_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic      [bra_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                                   cfg_pready
);

  import bra_pkg::*;

  localparam int NUM_WORDS = (MAX_ENTRIES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int LW        = $clog2(MAX_ENTRIES + 1);
  localparam int BW        = $clog2(NUM_WORDS * WORD_BITS + 1);
  localparam int PW        = $clog2(WORD_BITS);

  bra_state_t state_r, state_nxt;

  logic [REG_W-1:0]    entries_r, entries_nxt;
  logic [AW-1:0]       clr_r, clr_nxt;
  logic                pass2_r, pass2_nxt;
  logic                fresh_r, fresh_nxt;
  logic [COUNT_W-1:0]  found_r, found_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [KIND_W-1:0]    kind_r, kind_nxt;
  logic [INDEX_W-1:0]   idx_r, idx_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic [LW-1:0]        limit_r, limit_nxt;
  logic [AW-1:0]        word_r, word_nxt;
  logic [BW-1:0]        base_r, base_nxt;
  logic [WORD_BITS-1:0] work_r, work_nxt;
  logic [STATUS_W-1:0]  pend_status_r, pend_status_nxt;
  logic [ENTRY_W-1:0]   pend_entry_r, pend_entry_nxt;
  logic                 pend_bit_r, pend_bit_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [ENTRY_W-1:0]   out_entry_r, out_entry_nxt;
  logic                 out_bit_r, out_bit_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 cfg_wr;
  logic [LW-1:0]        eff_limit;
  logic [KIND_W-1:0]    in_kind;
  logic [INDEX_W-1:0]   in_idx;
  logic [COUNT_W-1:0]   in_count;
  logic                 in_acc;
  logic                 slot_free;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  logic [WORD_BITS-1:0] cur_word;
  logic                 pick_any;
  logic [PW-1:0]        pick_pos;
  logic [PW-1:0]        bit_pos;
  logic                 emit;
  logic [STATUS_W-1:0]  emit_status;
  logic [ENTRY_W-1:0]   emit_entry;
  logic                 emit_bit;
  logic                 emit_last;

  assign in_kind  = in_tuser;
  assign in_idx   = in_tdata[INDEX_W-1:0];
  assign in_count = in_tdata[INDEX_W +: COUNT_W];
  assign in_acc   = in_tvalid && in_tready;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[CFG_ADDR_W-1] == REG_ENTRIES_IN_USE);
  assign cfg_prdata = (cfg_paddr[CFG_ADDR_W-1] == REG_ENTRIES_IN_USE)
                      ? CFG_DATA_W'(entries_r) : '0;
  assign entries_nxt = cfg_wr ? cfg_pwdata[REG_W-1:0] : entries_r;

  assign eff_limit = (32'(entries_r) > 32'(MAX_ENTRIES)) ? LW'(MAX_ENTRIES)
                                                         : LW'(entries_r);

  assign slot_free = !out_valid_r || out_tready;
  assign cur_word  = fresh_r ? ram_rdata : work_r;
  assign bit_pos   = idx_r[PW-1:0];

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - ENTRY_W - 1)'(0), out_bit_r, out_entry_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  bra_bitmap_ram #(
    .DEPTH  (NUM_WORDS),
    .WIDTH  (WORD_BITS),
    .ADDR_W (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bra_pick_unit #(
    .WORD_BITS (WORD_BITS),
    .BASE_W    (BW),
    .LIMIT_W   (LW),
    .POS_W     (PW)
  ) u_pick (
    .word_i  (cur_word),
    .base_i  (base_r),
    .limit_i (limit_r),
    .any_o   (pick_any),
    .pos_o   (pick_pos)
  );

  always_comb begin
    state_nxt       = state_r;
    clr_nxt         = clr_r;
    pass2_nxt       = pass2_r;
    fresh_nxt       = fresh_r;
    found_nxt       = found_r;
    kind_nxt        = kind_r;
    idx_nxt         = idx_r;
    count_nxt       = count_r;
    limit_nxt       = limit_r;
    word_nxt        = word_r;
    base_nxt        = base_r;
    work_nxt        = work_r;
    pend_status_nxt = pend_status_r;
    pend_entry_nxt  = pend_entry_r;
    pend_bit_nxt    = pend_bit_r;
    in_tready       = (state_r == ST_IDLE);
    ram_we          = 1'b0;
    ram_waddr       = word_r;
    ram_wdata       = cur_word;
    ram_re          = 1'b0;
    ram_raddr       = '0;
    emit            = 1'b0;
    emit_status     = pend_status_r;
    emit_entry      = pend_entry_r;
    emit_bit        = pend_bit_r;
    emit_last       = 1'b1;

    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(NUM_WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          kind_nxt     = in_kind;
          idx_nxt      = in_idx;
          count_nxt    = in_count;
          limit_nxt    = eff_limit;
          pend_bit_nxt = 1'b0;
          if (in_kind == KIND_ALLOC) begin
            if (in_count == '0 || 32'(in_count) > 32'(MAX_RUN)) begin
              pend_status_nxt = STAT_NO_SPACE;
              pend_entry_nxt  = '0;
              state_nxt       = ST_EMIT;
            end else begin
              found_nxt = '0;
              pass2_nxt = 1'b0;
              fresh_nxt = 1'b1;
              word_nxt  = '0;
              base_nxt  = '0;
              ram_re    = 1'b1;
              ram_raddr = '0;
              state_nxt = ST_WALK;
            end
          end else if (32'(in_idx) >= 32'(eff_limit)) begin
            pend_status_nxt = STAT_RANGE;
            pend_entry_nxt  = in_idx;
            state_nxt       = ST_EMIT;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = AW'(in_idx >> PW);
            state_nxt = ST_RMW;
          end
        end
      end
      ST_RMW: begin
        ram_waddr       = AW'(idx_r >> PW);
        pend_status_nxt = STAT_OK;
        pend_entry_nxt  = idx_r;
        case (kind_r)
          KIND_SET: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata | (WORD_BITS'(1) << bit_pos);
          end
          KIND_CLEAR: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata & ~(WORD_BITS'(1) << bit_pos);
          end
          KIND_TEST: begin
            pend_bit_nxt = ram_rdata[bit_pos];
          end
          default: begin
            pend_bit_nxt = 1'b0;
          end
        endcase
        state_nxt = ST_EMIT;
      end
      ST_WALK: begin
        if (!pick_any || found_r == count_r) begin
          ram_we    = pass2_r;
          fresh_nxt = 1'b1;
          if (found_r == count_r) begin
            if (!pass2_r) begin
              pass2_nxt = 1'b1;
              found_nxt = '0;
              word_nxt  = '0;
              base_nxt  = '0;
              ram_re    = 1'b1;
              ram_raddr = '0;
            end else begin
              state_nxt = ST_IDLE;
            end
          end else if (32'(base_r) + 32'(WORD_BITS) >= 32'(limit_r)) begin
            pend_status_nxt = STAT_NO_SPACE;
            pend_entry_nxt  = '0;
            state_nxt       = ST_EMIT;
          end else begin
            word_nxt  = word_r + AW'(1);
            base_nxt  = base_r + BW'(WORD_BITS);
            ram_re    = 1'b1;
            ram_raddr = word_r + AW'(1);
          end
        end else if (!pass2_r || slot_free) begin
          emit        = pass2_r;
          emit_status = STAT_OK;
          emit_entry  = ENTRY_W'(32'(base_r) + 32'(pick_pos));
          emit_bit    = 1'b0;
          emit_last   = (found_r + COUNT_W'(1) == count_r);
          work_nxt    = cur_word | (WORD_BITS'(1) << pick_pos);
          fresh_nxt   = 1'b0;
          found_nxt   = found_r + COUNT_W'(1);
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          emit      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_entry_nxt  = out_entry_r;
    out_bit_nxt    = out_bit_r;
    out_last_nxt   = out_last_r;
    if (emit) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = emit_status;
      out_entry_nxt  = emit_entry;
      out_bit_nxt    = emit_bit;
      out_last_nxt   = emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      entries_r   <= ENTRIES_RESET;
      clr_r       <= '0;
      pass2_r     <= 1'b0;
      fresh_r     <= 1'b0;
      found_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      entries_r   <= entries_nxt;
      clr_r       <= clr_nxt;
      pass2_r     <= pass2_nxt;
      fresh_r     <= fresh_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r        <= kind_nxt;
    idx_r         <= idx_nxt;
    count_r       <= count_nxt;
    limit_r       <= limit_nxt;
    word_r        <= word_nxt;
    base_r        <= base_nxt;
    work_r        <= work_nxt;
    pend_status_r <= pend_status_nxt;
    pend_entry_r  <= pend_entry_nxt;
    pend_bit_r    <= pend_bit_nxt;
    out_status_r  <= out_status_nxt;
    out_entry_r   <= out_entry_nxt;
    out_bit_r     <= out_bit_nxt;
    out_last_r    <= out_last_nxt;
  end

`ifndef SYNTHESIS
  a_found_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (found_r <= count_r))
    else $error("pick count passed the requested count");

  a_write_owner: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_CLEAR || state_r == ST_RMW
                || (state_r == ST_WALK && pass2_r)))
    else $error("bitmap written outside clear, update or commit walk");

  a_probe_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK && !pass2_r) |-> !emit)
    else $error("result emitted during the probe walk");

  a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && out_valid_r) |-> out_tready)
    else $error("result overwrote a waiting item");
`endif

endmodule : bitmap_run_allocator
`default_nettype wire

// ----- verif/bitmap_run_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_run_checker
// Watches the request, result and register channels of the allocator. Keeps
// its own occupancy bitmap and entry limit, works out the results of every
// accepted request, and compares each result item field by field in order.
// Register reads are checked against the last value written.
// ----------------------------------------------------------------------------
module bitmap_run_checker
  import bra_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [KIND_W-1:0]      in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic [STATUS_W-1:0]    out_tuser,
  input  logic                   out_tlast,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [CFG_DATA_W-1:0]  cfg_pwdata,
  input  logic [CFG_DATA_W-1:0]  cfg_prdata,
  input  logic                   cfg_pready,
  output int                     fail_count,
  output int                     outstanding,
  output int                     checked_count
);

  localparam int NUM_WORDS = MAX_ENTRIES_DEF / WORD_BITS_DEF;
  localparam logic [CFG_ADDR_W-1:0] ENTRIES_ADDR = CFG_ADDR_W'(4 * REG_ENTRIES_IN_USE);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ENTRY_W-1:0]  entry;
    logic                bit_value;
    logic                last;
  } alloc_result_t;

  logic [WORD_BITS_DEF-1:0] occ_words [NUM_WORDS];
  logic [REG_W-1:0]         entries_cfg;
  alloc_result_t            pending_results [$];

  function automatic bit entry_used(int e);
    return occ_words[e / WORD_BITS_DEF][e % WORD_BITS_DEF];
  endfunction

  task automatic mark_entry(int e, bit used);
    occ_words[e / WORD_BITS_DEF][e % WORD_BITS_DEF] = used;
  endtask

  task automatic queue_result(logic [STATUS_W-1:0] status, int entry, bit bv, bit last);
    alloc_result_t r;
    r.status    = status;
    r.entry     = ENTRY_W'(entry);
    r.bit_value = bv;
    r.last      = last;
    pending_results.push_back(r);
  endtask

  task automatic predict_request(logic [KIND_W-1:0] kind, int index, int count);
    int lim;
    int picks [$];
    lim = (entries_cfg > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : int'(entries_cfg);
    if (kind == KIND_ALLOC) begin
      if (count == 0 || count > MAX_RUN_DEF) begin
        queue_result(STAT_NO_SPACE, 0, 1'b0, 1'b1);
      end else begin
        for (int e = 0; e < lim && picks.size() < count; e++) begin
          if (!entry_used(e)) picks.push_back(e);
        end
        if (picks.size() < count) begin
          queue_result(STAT_NO_SPACE, 0, 1'b0, 1'b1);
        end else begin
          foreach (picks[k]) begin
            mark_entry(picks[k], 1'b1);
            queue_result(STAT_OK, picks[k], 1'b0, k == picks.size() - 1);
          end
        end
      end
    end else if (index >= lim) begin
      queue_result(STAT_RANGE, index, 1'b0, 1'b1);
    end else begin
      case (kind)
        KIND_SET: begin
          mark_entry(index, 1'b1);
          queue_result(STAT_OK, index, 1'b0, 1'b1);
        end
        KIND_CLEAR: begin
          mark_entry(index, 1'b0);
          queue_result(STAT_OK, index, 1'b0, 1'b1);
        end
        default: begin
          queue_result(STAT_OK, index, entry_used(index), 1'b1);
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    alloc_result_t got;
    alloc_result_t want;
    if (!rst_n) begin
      foreach (occ_words[w]) occ_words[w] = '0;
      entries_cfg = ENTRIES_RESET;
      pending_results.delete();
      fail_count = 0;
      checked_count = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr == ENTRIES_ADDR) begin
        if (cfg_pwrite) begin
          entries_cfg = cfg_pwdata[REG_W-1:0];
        end else if (cfg_prdata !== CFG_DATA_W'(entries_cfg)) begin
          fail_count++;
          $display("%0t: register read mismatch: expected %0d, got %0d",
                   $time, entries_cfg, cfg_prdata);
        end
      end
      if (in_tvalid && in_tready) begin
        predict_request(in_tuser, int'(in_tdata[INDEX_W-1:0]),
                        int'(in_tdata[INDEX_W +: COUNT_W]));
      end
      if (out_tvalid && out_tready) begin
        got = {out_tuser, out_tdata[ENTRY_W-1:0], out_tdata[ENTRY_W], out_tlast};
        checked_count++;
        if (pending_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result: expected none, got %0d/%0d/%0d/%0d",
                   $time, got.status, got.entry, got.bit_value, got.last);
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status || got.entry !== want.entry ||
              got.bit_value !== want.bit_value || got.last !== want.last) begin
            fail_count++;
            $display("%0t: result mismatch: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                     $time, want.status, want.entry, want.bit_value, want.last,
                     got.status, got.entry, got.bit_value, got.last);
          end
        end
      end
    end
    outstanding = pending_results.size();
  end

endmodule

// ----- verif/bitmap_run_allocator_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_run_allocator_test
// Drives allocate, set, clear and test requests into the allocator under
// several entry limits, including zero, one and values past the bitmap size.
// A directed opening covers the edge cases; random traffic with random
// gaps on both channels follows. The checker module predicts and compares.
// ----------------------------------------------------------------------------
module bitmap_run_allocator_test;
  import bra_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] ENTRIES_ADDR = CFG_ADDR_W'(4 * REG_ENTRIES_IN_USE);
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 2 * (MAX_ENTRIES_DEF / WORD_BITS_DEF + MAX_RUN_DEF) + 8;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // index, count, zero pad
  logic [KIND_W-1:0]      in_tuser;   // kind
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // entry, bit_value, zero pad
  logic [STATUS_W-1:0]    out_tuser;  // status
  logic                   out_tlast;
  logic                   cfg_psel;
  logic                   cfg_penable;
  logic                   cfg_pwrite;
  logic [CFG_ADDR_W-1:0]  cfg_paddr;
  logic [CFG_DATA_W-1:0]  cfg_pwdata;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  int fail_count;
  int outstanding;
  int checked_count;
  int cur_entries;
  int sent;
  int settings_used;
  int quiet_cycles;
  bit in_calm;
  bit out_calm;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bitmap_run_allocator dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  bitmap_run_checker results_check (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready,
    .fail_count, .outstanding, .checked_count
  );

  task automatic send_req(logic [KIND_W-1:0] kind, int index, int count);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = kind;
    in_tdata  = {1'b0, COUNT_W'(count), INDEX_W'(index)};
    do @(posedge clk); while (in_tready !== 1'b1);
    @(negedge clk);
    sent++;
  endtask

  task automatic settle();
    in_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // write the limit, then read it back
  task automatic program_entries(int value);
    settle();
    cfg_psel    = 1'b1;
    cfg_pwrite  = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr   = ENTRIES_ADDR;
    cfg_pwdata  = CFG_DATA_W'(value);
    @(negedge clk) cfg_penable = 1'b1;
    @(negedge clk);
    cfg_pwrite  = 1'b0;
    cfg_penable = 1'b0;
    @(negedge clk) cfg_penable = 1'b1;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cur_entries = value;
    settings_used++;
  endtask

  task automatic run_random(int n);
    int lim;
    int pick;
    int idx;
    int cnt;
    logic [KIND_W-1:0] kind;
    lim = (cur_entries > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : cur_entries;
    for (int k = 0; k < n; k++) begin
      if (k % 20 == 0) in_calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      kind = (pick < 35) ? KIND_ALLOC : (pick < 55) ? KIND_SET :
             (pick < 80) ? KIND_CLEAR : KIND_TEST;
      idx = (lim > 0 && $urandom_range(0, 99) < 85) ? $urandom_range(0, lim - 1)
                                                     : $urandom_range(0, 1023);
      cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
      send_req(kind, idx, cnt);
    end
  endtask

  initial begin : result_side
    int w;
    int handled;
    handled = 0;
    out_tready = 1'b0;
    forever begin
      if (handled % 32 == 0) out_calm = ($urandom_range(0, 3) == 0);
      w = out_calm ? 0 : $urandom_range(0, 6);
      if (w > 0) begin
        out_tready = 1'b0;
        repeat (w) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      @(negedge clk);
      handled++;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    int settings [10];
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = KIND_ALLOC;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    quiet_cycles = 0;
    cur_entries  = int'(ENTRIES_RESET);
    sent         = 0;
    settings_used = 0;
    in_calm      = 1'b0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    send_req(KIND_TEST, 0, 1);
    send_req(KIND_ALLOC, 777, 1);
    send_req(KIND_ALLOC, 0, 16);
    send_req(KIND_TEST, 16, 1);
    send_req(KIND_TEST, 17, 1);
    send_req(KIND_SET, 1023, 1);
    send_req(KIND_TEST, 1023, 1);
    send_req(KIND_SET, 1023, 1);
    send_req(KIND_CLEAR, 500, 1);
    send_req(KIND_CLEAR, 5, 1);
    send_req(KIND_ALLOC, 0, 3);
    send_req(KIND_ALLOC, 0, 0);
    send_req(KIND_ALLOC, 0, 17);
    send_req(KIND_ALLOC, 1023, 31);
    send_req(KIND_CLEAR, 1023, 1);
    send_req(KIND_TEST, 1023, 1);
    program_entries(8);
    send_req(KIND_SET, 8, 1);
    send_req(KIND_SET, 1023, 1);
    send_req(KIND_CLEAR, 3, 1);
    send_req(KIND_ALLOC, 0, 16);
    send_req(KIND_ALLOC, 0, 1);
    program_entries(0);
    send_req(KIND_ALLOC, 0, 1);
    send_req(KIND_TEST, 0, 1);
    program_entries(2047);
    send_req(KIND_SET, 1023, 1);
    send_req(KIND_TEST, 1023, 1);

    settings = '{1024, 1, 64, 2047, 16, $urandom_range(1, 1024), 1024, 300, 8, 1024};
    foreach (settings[p]) begin
      program_entries(settings[p]);
      run_random(30);
    end

    settle();
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("Covered %0d requests of all four kinds under %0d entry limits,",
             sent, settings_used);
    $display("including limits of zero, one and past the bitmap; %0d results compared.",
             checked_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
